FILE: rtl/core/yprgb_pkg.sv
// Package for the YUV pixel-pair to RGB24 converter.
// Holds the word types, register indexes, conversion coefficients and the clamp.
// No dependencies.
`default_nettype none

package yprgb_pkg;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  red_first;
		logic [7:0]  green_first;
		logic [7:0]  blue_first;
		logic [7:0]  red_second;
		logic [7:0]  green_second;
		logic [7:0]  blue_second;
		logic [23:0] dest_pixel_index;
		logic        frame_last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Load enables of the pipeline stages behind the input register.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} adv_t;

	localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;

	localparam logic FMT_NV12 = 1'b0;
	localparam logic FMT_YUYV = 1'b1;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	localparam logic signed [9:0]  LUMA_OFFSET   = 10'sd16;
	localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;
	localparam logic signed [19:0] K_Y     = 20'sd298;
	localparam logic signed [19:0] K_RV    = 20'sd409;
	localparam logic signed [19:0] K_GU    = 20'sd100;
	localparam logic signed [19:0] K_GV    = 20'sd208;
	localparam logic signed [19:0] K_BU    = 20'sd516;
	localparam logic signed [19:0] K_ROUND = 20'sd128;

	// Floor of v/256 clamped to 0..255.
	function automatic logic [7:0] clamp_pix(input logic signed [19:0] v);
		logic [7:0] res;
		if (v[19]) begin
			res = 8'd0;
		end else if (v[18:16] != 3'd0) begin
			res = 8'd255;
		end else begin
			res = v[15:8];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/yprgb_lane.sv
// One pixel conversion lane: BT.601 integer YCbCr to clamped RGB.
// Two registered stages (products, then sums and clamp); uses yprgb_pkg.
`default_nettype none

module yprgb_lane (
	input  wire logic           clk,
	input  wire yprgb_pkg::adv_t adv,
	input  wire logic [7:0]     luma,
	input  wire logic [7:0]     cb,
	input  wire logic [7:0]     cr,
	output yprgb_pkg::pix_t     pix
);
	import yprgb_pkg::*;

	logic signed [9:0]  c_d;
	logic signed [9:0]  d_d;
	logic signed [9:0]  e_d;
	logic signed [19:0] c_x;
	logic signed [19:0] d_x;
	logic signed [19:0] e_x;

	logic signed [19:0] y298_s2;
	logic signed [19:0] v409_s2;
	logic signed [19:0] u100_s2;
	logic signed [19:0] v208_s2;
	logic signed [19:0] u516_s2;

	logic signed [19:0] r_sum;
	logic signed [19:0] g_sum;
	logic signed [19:0] b_sum;
	pix_t               pix_s3;

	always_comb begin
		c_d = $signed({2'b00, luma}) - LUMA_OFFSET;
		d_d = $signed({2'b00, cb}) - CHROMA_OFFSET;
		e_d = $signed({2'b00, cr}) - CHROMA_OFFSET;
		c_x = $signed({{10{c_d[9]}}, c_d});
		d_x = $signed({{10{d_d[9]}}, d_d});
		e_x = $signed({{10{e_d[9]}}, e_d});
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			y298_s2 <= c_x * K_Y;
			v409_s2 <= e_x * K_RV;
			u100_s2 <= d_x * K_GU;
			v208_s2 <= e_x * K_GV;
			u516_s2 <= d_x * K_BU;
		end
	end

	always_comb begin
		r_sum = y298_s2 + v409_s2 + K_ROUND;
		g_sum = y298_s2 - u100_s2 - v208_s2 + K_ROUND;
		b_sum = y298_s2 + u516_s2 + K_ROUND;
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			pix_s3.red   <= clamp_pix(r_sum);
			pix_s3.green <= clamp_pix(g_sum);
			pix_s3.blue  <= clamp_pix(b_sum);
		end
	end

	assign pix = pix_s3;

endmodule

`default_nettype wire

FILE: rtl/core/yprgb_merge.sv
// Merge stage: destination index pipeline and packing of both lanes into one word.
// Row times width in stage s2; s3 adds (YUYV) or subtracts (NV12) the column; uses yprgb_pkg.
`default_nettype none

module yprgb_merge #(
	parameter int CW = 13,
	parameter int RW = 13
) (
	input  wire logic               clk,
	input  wire yprgb_pkg::adv_t    adv,
	input  wire logic [CW-1:0]      col_s1,
	input  wire logic [RW-1:0]      row_s1,
	input  wire logic [CW-1:0]      w_s1,
	input  wire logic               fmt_s1,
	input  wire logic               last_s1,
	input  wire yprgb_pkg::pix_t    pix_first,
	input  wire yprgb_pkg::pix_t    pix_second,
	output yprgb_pkg::out_word_t    word
);
	import yprgb_pkg::*;

	localparam int PW = RW + CW;
	localparam int XW = (PW + 1 > 24) ? PW + 1 : 24;

	logic [RW-1:0] row_sel;
	logic [PW-1:0] prod_s2;
	logic [CW-1:0] col_s2;
	logic          fmt_s2;
	logic          last_s2;
	logic [XW-1:0] idx_sum;
	logic [23:0]   idx_s3;
	logic          last_s3;

	// NV12 rows are mirrored, so the index counts back from the end of the row.
	always_comb begin
		if (fmt_s1 == FMT_YUYV) begin
			row_sel = row_s1;
		end else begin
			row_sel = row_s1 + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			prod_s2 <= PW'(row_sel) * PW'(w_s1);
			col_s2  <= col_s1;
			fmt_s2  <= fmt_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		if (fmt_s2 == FMT_YUYV) begin
			idx_sum = XW'(prod_s2) + XW'(col_s2);
		end else begin
			idx_sum = XW'(prod_s2) - XW'(col_s2) - XW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			idx_s3  <= idx_sum[23:0];
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		word.red_first        = pix_first.red;
		word.green_first      = pix_first.green;
		word.blue_first       = pix_first.blue;
		word.red_second       = pix_second.red;
		word.green_second     = pix_second.green;
		word.blue_second      = pix_second.blue;
		word.dest_pixel_index = idx_s3;
		word.frame_last       = last_s3;
	end

endmodule

`default_nettype wire

FILE: rtl/core/yuv_pair_to_rgb24_converter_core.sv
// YUV pixel pair to RGB24 converter: registers, position counters, two pixel lanes, merge.
// Takes one word per cycle unless out_stall holds with every stage full.
// The three stages (input register, products, sums/clamp/index) each advance when the
// next one is empty or moving, so a new word is taken while a result waits if a stage is empty.
// Reset clears the position counters and valid flags and loads the register defaults.
// Depends on yprgb_pkg, yprgb_lane and yprgb_merge.
`default_nettype none

module yuv_pair_to_rgb24_converter_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire yprgb_pkg::in_word_t  in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output yprgb_pkg::out_word_t      out_word
);
	import yprgb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = (CW > 13) ? CW : 13;
	localparam int EH = (RW > 13) ? RW : 13;

	function automatic logic [CW-1:0] eff_width(input logic [12:0] v);
		logic [EW-1:0] t;
		t = EW'(v);
		if (t > EW'(MAX_WIDTH)) begin
			t = EW'(MAX_WIDTH);
		end
		if (t < EW'(2)) begin
			t = EW'(2);
		end
		t[0] = 1'b0;
		return t[CW-1:0];
	endfunction

	function automatic logic [RW-1:0] eff_height(input logic [12:0] v);
		logic [EH-1:0] t;
		t = EH'(v);
		if (t > EH'(MAX_HEIGHT)) begin
			t = EH'(MAX_HEIGHT);
		end
		if (t < EH'(1)) begin
			t = EH'(1);
		end
		return t[RW-1:0];
	endfunction

	// Configuration registers.
	logic          fmt_q;
	logic [12:0]   width_q;
	logic [12:0]   height_q;
	logic [CW-1:0] w_eff_q;
	logic [RW-1:0] h_eff_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_NV12;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			w_eff_q  <= eff_width(WIDTH_RESET);
			h_eff_q  <= eff_height(HEIGHT_RESET);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SOURCE_FORMAT: fmt_q <= pwdata[0];
				REG_FRAME_WIDTH: begin
					width_q <= pwdata[12:0];
					w_eff_q <= eff_width(pwdata[12:0]);
				end
				REG_FRAME_HEIGHT: begin
					height_q <= pwdata[12:0];
					h_eff_q  <= eff_height(pwdata[12:0]);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SOURCE_FORMAT: prdata = {31'd0, fmt_q};
			REG_FRAME_WIDTH:   prdata = {19'd0, width_q};
			REG_FRAME_HEIGHT:  prdata = {19'd0, height_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Pipeline control.
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic in_acc;
	adv_t adv;

	assign rdy_s3     = !v_s3 || !out_stall;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign in_stall   = !rdy_s1;
	assign in_acc     = in_valid && rdy_s1;
	assign adv.ld_s2  = v_s1 && rdy_s2;
	assign adv.ld_s3  = v_s2 && rdy_s3;
	assign out_valid  = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Position counters. A column or row left beyond a changed size wraps on entry.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          wrap_in;
	logic [CW-1:0] col_e;
	logic [RW:0]   row_t;
	logic [RW-1:0] row_e;
	logic [CW:0]   col_n;
	logic [RW:0]   row_p1;
	logic          end_row;
	logic          end_frame;
	logic          last_d;

	always_comb begin
		wrap_in   = col_q >= w_eff_q;
		col_e     = wrap_in ? '0 : col_q;
		row_t     = {1'b0, row_q} + (RW+1)'(wrap_in);
		row_e     = (row_t >= {1'b0, h_eff_q}) ? '0 : row_t[RW-1:0];
		col_n     = {1'b0, col_e} + (CW+1)'(2);
		row_p1    = {1'b0, row_e} + (RW+1)'(1);
		end_row   = col_n >= {1'b0, w_eff_q};
		end_frame = row_p1 >= {1'b0, h_eff_q};
		last_d    = end_row && end_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_p1[RW-1:0];
			end else begin
				col_q <= col_n[CW-1:0];
				row_q <= row_e;
			end
		end
	end

	// Input stage register.
	in_word_t      word_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] w_s1;
	logic          fmt_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= in_word;
			col_s1  <= col_e;
			row_s1  <= row_e;
			w_s1    <= w_eff_q;
			fmt_s1  <= fmt_q;
			last_s1 <= last_d;
		end
	end

	pix_t pix_first;
	pix_t pix_second;

	yprgb_lane u_lane_first (
		.clk  (clk),
		.adv  (adv),
		.luma (word_s1.luma_first),
		.cb   (word_s1.chroma_blue),
		.cr   (word_s1.chroma_red),
		.pix  (pix_first)
	);

	yprgb_lane u_lane_second (
		.clk  (clk),
		.adv  (adv),
		.luma (word_s1.luma_second),
		.cb   (word_s1.chroma_blue),
		.cr   (word_s1.chroma_red),
		.pix  (pix_second)
	);

	yprgb_merge #(
		.CW (CW),
		.RW (RW)
	) u_merge (
		.clk        (clk),
		.adv        (adv),
		.col_s1     (col_s1),
		.row_s1     (row_s1),
		.w_s1       (w_s1),
		.fmt_s1     (fmt_s1),
		.last_s1    (last_s1),
		.pix_first  (pix_first),
		.pix_second (pix_second),
		.word       (out_word)
	);

	// The input is held off only when every stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with an empty stage");

	// The final pair of a frame returns the counters to the origin.
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_d) |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared after the last pair of a frame");

	// Pairs start on even columns.
	a_col_even: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !col_q[0])
		else $error("column counter left an even position");

	// The flag registered at the input stage matches the one computed at entry.
	a_last_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (last_s1 == $past(last_d)))
		else $error("frame end flag lost at the input stage");

endmodule

`default_nettype wire
